/* sv/agf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package agf_pkg;

    localparam int unsigned FIFO_DEPTH = 2048;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int unsigned Q_SHIFT    = 15;
    localparam int unsigned SHIFTED_W  = PROD_W - Q_SHIFT;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(32768);

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN = 1'b0,
        REG_MUTE = 1'b1
    } cfg_reg_t;

    // Control that travels with a pop through the gain pipeline
    typedef struct packed {
        logic valid;
        logic taken;
        logic zero;
    } pop_ctl_t;

    // Floor of product / 2^15, clamped to the signed sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_q15(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [SHIFTED_W-1:0] shifted;
        logic signed [SHIFTED_W-1:0] max_v;
        logic signed [SHIFTED_W-1:0] min_v;
        logic signed [SAMPLE_W-1:0]  res;
        shifted = SHIFTED_W'(prod >>> Q_SHIFT);
        max_v   = SHIFTED_W'(2 ** (SAMPLE_W - 1) - 1);
        min_v   = -SHIFTED_W'(2 ** (SAMPLE_W - 1));
        if (shifted > max_v)
        begin
            res = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (shifted < min_v)
        begin
            res = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            res = shifted[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* sv/agf_gain_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none

module agf_gain_pipe (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                advance,
    input  wire agf_pkg::pop_ctl_t                   s1_ctl,
    input  wire logic signed [agf_pkg::SAMPLE_W-1:0] s1_sample,
    input  wire logic        [agf_pkg::GAIN_W-1:0]   gain,
    output logic                                     out_valid,
    output logic signed      [agf_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                     from_fifo
);
    import agf_pkg::*;

    pop_ctl_t                   s2_ctl_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic signed [SAMPLE_W-1:0] sample_out_next;
    logic                       from_fifo_reg;

    // Signed sample times unsigned gain, both widened to the product width
    assign prod_next = $signed({{(PROD_W-SAMPLE_W){s1_sample[SAMPLE_W-1]}}, s1_sample})
                     * $signed({{(PROD_W-GAIN_W){1'b0}}, gain});

    assign sample_out_next = s2_ctl_reg.zero ? '0 : sat_q15(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_ctl_reg    <= s1_ctl;
            out_valid_reg <= s2_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg       <= prod_next;
            sample_out_reg <= sample_out_next;
            from_fifo_reg  <= s2_ctl_reg.taken;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign from_fifo  = from_fifo_reg;

endmodule

`default_nettype wire

/* sv/audio_fifo_drop_oldest_gain_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Audio sample FIFO of FIFO_DEPTH signed 16-bit entries that overwrites the
// oldest sample when a push finds it full. Each input transaction is a push,
// a pop or a clear, and one is taken every clock cycle while the result side
// keeps up. Push, clear and the unused fourth mode give no result; every pop
// gives exactly one, carried to the result port through the pipeline registers,
// which move only while the pipeline advances: the registered read port of the
// sample memory, the 16x17 gain product, and the output register that holds
// the shift-by-15 and saturation. A pop of an empty FIFO returns zero with
// from_fifo low; a pop while muted still consumes the sample and returns zero
// with from_fifo high. The gain is unsigned Q1.15 (32768 is unity) and larger
// values saturate. The user must write gain and mute through the cfg port
// only while no transaction is in flight; the block does not enforce this.
// When the output register holds an untaken result the whole pipeline stalls
// and in_ready drops; it never drops otherwise. No clearing pass is needed
// after reset: the fill count keeps unwritten entries from ever being read.

module audio_fifo_drop_oldest_gain_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // config write port
    input  wire logic                                 cfg_we,
    input  wire logic        [agf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [agf_pkg::GAIN_W-1:0]    cfg_wdata,
    // input channel
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic        [1:0]                    mode,
    input  wire logic signed [agf_pkg::SAMPLE_W-1:0]  sample_in,
    // result channel
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed      [agf_pkg::SAMPLE_W-1:0]  sample_out,
    output logic                                      from_fifo
);
    import agf_pkg::*;

    logic [SAMPLE_W-1:0] mem [FIFO_DEPTH];

    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [GAIN_W-1:0]   gain_reg;
    logic                mute_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    pop_ctl_t            s1_ctl_reg;
    pop_ctl_t            s1_ctl_next;

    logic                advance;
    logic                accept;
    logic                do_push;
    logic                empty;
    logic                full;
    logic [PTR_W-1:0]    wr_ptr_inc;
    logic [PTR_W-1:0]    rd_ptr_inc;

    // Stall every stage while the output register holds an untaken result
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(FIFO_DEPTH));

    // Wrap pointers at the last entry, also for depths that are not a power of two
    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        do_push     = 1'b0;
        s1_ctl_next = '0;
        if (accept)
        begin
            unique case (mode_t'(mode))
                MODE_PUSH:
                begin
                    do_push     = 1'b1;
                    wr_ptr_next = wr_ptr_inc;
                    // Full: drop the oldest sample, count holds
                    if (full)
                    begin
                        rd_ptr_next = rd_ptr_inc;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_POP:
                begin
                    s1_ctl_next.valid = 1'b1;
                    s1_ctl_next.taken = !empty;
                    s1_ctl_next.zero  = empty || mute_reg;
                    if (!empty)
                    begin
                        rd_ptr_next = rd_ptr_inc;
                        count_next  = count_reg - 1'b1;
                    end
                end
                MODE_CLEAR:
                begin
                    rd_ptr_next = wr_ptr_reg;
                    count_next  = '0;
                end
                default:
                begin
                    // unused mode: ignore the transaction
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            s1_ctl_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (advance)
            begin
                s1_ctl_reg <= s1_ctl_next;
            end
        end
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= UNITY_GAIN;
            mute_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN: gain_reg <= cfg_wdata;
                REG_MUTE: mute_reg <= cfg_wdata[0];
                default:  ;
            endcase
        end
    end

    // Sample memory: one write port, one registered read port. The read
    // always targets the oldest entry; the pop's control says whether it counts.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= sample_in;
        end
        if (advance)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    agf_gain_pipe u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .s1_ctl     (s1_ctl_reg),
        .s1_sample  ($signed(rd_data_reg)),
        .gain       (gain_reg),
        .out_valid  (out_valid),
        .sample_out (sample_out),
        .from_fifo  (from_fifo)
    );

endmodule

`default_nettype wire

/* sv/agf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module agf_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 cfg_we,
    input wire logic        [agf_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic        [agf_pkg::GAIN_W-1:0]    cfg_wdata,
    input wire logic                                 in_ready,
    input wire logic                                 out_valid,
    input wire logic                                 out_ready,
    input wire logic signed [agf_pkg::SAMPLE_W-1:0]  sample_out,
    input wire logic                                 from_fifo
);
    import agf_pkg::*;

    logic mute_shadow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_shadow_reg <= 1'b0;
        end
        else if (cfg_we && (cfg_index == REG_MUTE))
        begin
            mute_shadow_reg <= cfg_wdata[0];
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(from_fifo))
        else $error("result changed while stalled");

    // Input side only stalls behind a waiting result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output");

    // Padding from an empty FIFO reads as zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !from_fifo |-> sample_out == '0)
        else $error("padding result is not zero");

    // Muted results read as zero
    a_mute_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mute_shadow_reg |-> sample_out == '0)
        else $error("muted result is not zero");

endmodule

bind audio_fifo_drop_oldest_gain_core agf_checker u_agf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .from_fifo  (from_fifo)
);

`default_nettype wire

/* verif/tb_audio_fifo_drop_oldest_gain_core.sv */
`timescale 1ns / 1ps

module tb_audio_fifo_drop_oldest_gain_core;
    import agf_pkg::*;

    // The package names only three modes; the fourth code is ignored by the block
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Cycles without any transaction on either channel before the run is abandoned
    localparam int unsigned IDLE_LIMIT   = 4000;
    // Length of the forced receiver stall that backs the block up into its input
    localparam int unsigned LONG_HOLD    = 300;
    // Pipeline is three stages deep; give it a margin before touching registers
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS  = 97;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       taken;
    } readout_t;

    // Tracks the ring buffer, the gain and mute settings, and the readouts that
    // every accepted pop must produce, in order.
    class fifo_readout_checker;
        logic signed [SAMPLE_W-1:0] samples [FIFO_DEPTH];
        int unsigned                rd_ptr;
        int unsigned                wr_ptr;
        int unsigned                fill;
        logic [GAIN_W-1:0]          gain;
        logic                       mute;
        readout_t                   pending_readouts [$];
        int unsigned                mismatches;

        function new();
            rd_ptr     = 0;
            wr_ptr     = 0;
            fill       = 0;
            gain       = UNITY_GAIN;
            mute       = 1'b0;
            mismatches = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [GAIN_W-1:0] value);
            if (idx == REG_GAIN)
            begin
                gain = value;
            end
            else
            begin
                mute = value[0];
            end
        endfunction

        // Floor of sample * gain / 2^15, clamped to the sample range
        function logic signed [SAMPLE_W-1:0] gained(logic signed [SAMPLE_W-1:0] s);
            longint prod;
            longint q;
            prod = longint'(s) * longint'(gain);
            q    = prod >>> Q_SHIFT;
            if (q > longint'(SAMPLE_MAX))
            begin
                q = longint'(SAMPLE_MAX);
            end
            else if (q < longint'(SAMPLE_MIN))
            begin
                q = longint'(SAMPLE_MIN);
            end
            return q[SAMPLE_W-1:0];
        endfunction

        function void note_transaction(logic [1:0] m, logic signed [SAMPLE_W-1:0] s);
            readout_t r;
            case (m)
                MODE_PUSH:
                begin
                    // A full buffer loses its oldest sample; the count stays put
                    if (fill == FIFO_DEPTH)
                    begin
                        rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
                    end
                    else
                    begin
                        fill++;
                    end
                    samples[wr_ptr] = s;
                    wr_ptr          = (wr_ptr + 1) % FIFO_DEPTH;
                end
                MODE_POP:
                begin
                    r.sample = '0;
                    r.taken  = 1'b0;
                    if (fill > 0)
                    begin
                        r.taken = 1'b1;
                        if (!mute)
                        begin
                            r.sample = gained(samples[rd_ptr]);
                        end
                        rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
                        fill--;
                    end
                    pending_readouts.push_back(r);
                end
                MODE_CLEAR:
                begin
                    rd_ptr = wr_ptr;
                    fill   = 0;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_readout(logic signed [SAMPLE_W-1:0] sample, logic taken);
            readout_t want;
            if (pending_readouts.size() == 0)
            begin
                $error("unexpected readout: sample_out %0d from_fifo %0b", sample, taken);
                mismatches++;
                return;
            end
            want = pending_readouts.pop_front();
            if (sample !== want.sample)
            begin
                $error("sample_out: expected %0d, actual %0d", want.sample, sample);
                mismatches++;
            end
            if (taken !== want.taken)
            begin
                $error("from_fifo: expected %0b, actual %0b", want.taken, taken);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_readouts.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [GAIN_W-1:0]          cfg_wdata;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 mode;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       from_fifo;

    fifo_readout_checker readouts = new();

    // Largest idle gap each side draws per transaction; zero gives back-to-back traffic
    int unsigned src_gap_max;
    int unsigned sink_gap_max;
    // Set by the stimulus to make the receiver serve the LONG_HOLD stall
    bit          hold_request;

    audio_fifo_drop_oldest_gain_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .from_fifo  (from_fifo)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bias toward the corners of the sample range so saturation gets hit often
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9, 0))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2: return '0;
            3: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one transaction after a random idle gap and hold it until accepted.
    // Valid stays high across back-to-back transactions, so it is driven once per step.
    task automatic send(input logic [1:0] m, input logic signed [SAMPLE_W-1:0] s);
        int unsigned gap;
        gap = $urandom_range(src_gap_max, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        sample_in <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        readouts.note_transaction(m, s);
    endtask

    // Mostly pushes and pops, with a few clears and ignored codes mixed in
    task automatic send_random(input int unsigned push_weight);
        int unsigned pick;
        logic [1:0]  m;
        pick = $urandom_range(99, 0);
        if (pick < push_weight)
        begin
            m = MODE_PUSH;
        end
        else if (pick < 92)
        begin
            m = MODE_POP;
        end
        else if (pick < 97)
        begin
            m = MODE_CLEAR;
        end
        else
        begin
            m = MODE_UNUSED;
        end
        send(m, random_sample());
    endtask

    // Drop valid, wait for every outstanding readout, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (readouts.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic configure(input logic [GAIN_W-1:0] g, input logic m);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_GAIN;
        cfg_wdata <= g;
        @(posedge clk);
        readouts.set_register(REG_GAIN, g);
        cfg_index <= REG_MUTE;
        cfg_wdata <= GAIN_W'(m);
        @(posedge clk);
        readouts.set_register(REG_MUTE, GAIN_W'(m));
        cfg_we    <= 1'b0;
    endtask

    // Check every readout that completes a handshake
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            readouts.check_readout(sample_out, from_fifo);
        end
    end

    // Receiver: draw a stall before each readout, or serve a long hold on request
    initial
    begin : readout_sink
        int unsigned gap;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                gap = $urandom_range(sink_gap_max, 0);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Abandon the run if no transaction moves for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned       p;
        int unsigned       i;
        int unsigned       push_weight;
        logic [GAIN_W-1:0] g;
        logic              mu;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_GAIN;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        mode         = MODE_PUSH;
        sample_in    = '0;
        src_gap_max  = 3;
        sink_gap_max = 3;
        hold_request = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed transactions at the reset settings (unity gain, unmuted).
        // Pop an empty buffer first: zero readout, nothing consumed.
        send(MODE_POP, '0);
        // Push the corners of the sample range and two alternating bit patterns
        send(MODE_PUSH, SAMPLE_MIN);
        send(MODE_PUSH, SAMPLE_MAX);
        send(MODE_PUSH, '0);
        send(MODE_PUSH, '1);
        send(MODE_PUSH, 16'sh0001);
        send(MODE_PUSH, 16'sh5555);
        send(MODE_PUSH, 16'shAAAA);
        // The unused mode code must leave the buffer alone
        send(MODE_UNUSED, '1);
        for (i = 0; i < 7; i++)
        begin
            send(MODE_POP, '0);
        end
        // Buffer is empty again
        send(MODE_POP, 16'sh7FFF);
        // Clear discards stored samples; the following pop finds nothing
        send(MODE_PUSH, 16'sh1234);
        send(MODE_PUSH, 16'shEDCB);
        send(MODE_CLEAR, '1);
        send(MODE_POP, '0);

        // Largest gain: store a run of samples, pop most of them so the gain
        // saturates, then clear a partly filled buffer.
        configure(16'hFFFF, 1'b0);
        src_gap_max  = 2;
        sink_gap_max = 2;
        for (i = 0; i < 60; i++)
        begin
            send(MODE_PUSH, random_sample());
        end
        src_gap_max = 6;
        for (i = 0; i < 50; i++)
        begin
            send(MODE_POP, random_sample());
        end
        send(MODE_CLEAR, random_sample());
        send(MODE_POP, random_sample());

        // Back-pressure: stall the receiver while pops keep arriving so the
        // output register fills and input ready drops.
        configure(UNITY_GAIN, 1'b0);
        src_gap_max  = 0;
        sink_gap_max = 4;
        for (i = 0; i < 40; i++)
        begin
            send(MODE_PUSH, random_sample());
        end
        hold_request = 1'b1;
        for (i = 0; i < 60; i++)
        begin
            send_random(30);
        end
        // Hold the sender until every readout is back, then resume
        drain();
        for (i = 0; i < 40; i++)
        begin
            send_random(46);
        end

        // Random phases, each with its own register settings and idle pattern
        for (p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    g = UNITY_GAIN;
                    mu = 1'b0;
                    push_weight = 46;
                end
                1:
                begin
                    g = '0;
                    mu = 1'b0;
                    push_weight = 50;
                end
                2:
                begin
                    g = '1;
                    mu = 1'b0;
                    push_weight = 46;
                end
                3:
                begin
                    g = UNITY_GAIN;
                    mu = 1'b1;
                    push_weight = 55;
                end
                4:
                begin
                    g = 16'd16384;
                    mu = 1'b0;
                    push_weight = 30;
                end
                5:
                begin
                    g = GAIN_W'($urandom_range(65535, 0));
                    mu = 1'b0;
                    push_weight = 60;
                end
                6:
                begin
                    g = 16'd1;
                    mu = 1'b0;
                    push_weight = 46;
                end
                default:
                begin
                    g = GAIN_W'($urandom_range(65535, 32769));
                    mu = 1'b0;
                    push_weight = 46;
                end
            endcase
            configure(g, mu);
            src_gap_max  = (p % 3 == 1) ? 0 : 12;
            sink_gap_max = (p % 4 == 2) ? 0 : 12;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                send_random(push_weight);
            end
        end

        // Wait out every readout and the pipeline tail before judging the run
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (readouts.mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
